// ===== rtl/kcl_pkg.sv =====
// ----------------------------------------------------------------------------
// kcl_pkg
// shared widths, reset values, register indexes and beat types for the
// keypad code lock
// ----------------------------------------------------------------------------
package kcl_pkg;

  localparam int NumKeys    = 10;
  localparam int LevelW     = 10;
  localparam int KeyW       = 4;
  localparam int LenW       = 4;
  localparam int DigitW     = 4;
  localparam int CodeW      = 32;
  localparam int CfgIdxW    = 2;
  localparam int MaxCodeLen = 8;

  localparam logic [LevelW-1:0] KeyMask =
    LevelW'((64'd1 << NumKeys) - 64'd1);

  localparam logic [LenW-1:0]  MaxLen          = LenW'(MaxCodeLen);
  localparam logic [CodeW-1:0] ResetCodeDigits = 32'h5891_7331;
  localparam logic [LenW-1:0]  ResetCodeLength = LenW'(MaxCodeLen);

  localparam logic [CfgIdxW-1:0] CfgCodeDigits = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgCodeLength = 2'd1;

  typedef struct packed {
    logic              valid;
    logic [LevelW-1:0] levels;
  } stage_t;

  typedef struct packed {
    logic            press_seen;
    logic [KeyW-1:0] pressed_key;
    logic [LenW-1:0] digits_matched;
    logic            unlocked;
  } result_t;

  // lowest set bit index, zero when none
  function automatic logic [KeyW-1:0] lowest_set(input logic [LevelW-1:0] v);
    logic [KeyW-1:0] k;
    k = '0;
    for (int i = LevelW - 1; i >= 0; i--) begin
      if (v[i]) begin
        k = KeyW'(i);
      end
    end
    return k;
  endfunction

endpackage

// ===== rtl/kcl_if.sv =====
// ----------------------------------------------------------------------------
// kcl_if
// valid/ready channels of the keypad code lock: scans, results, config writes
// ----------------------------------------------------------------------------
interface kcl_scan_if;
  logic                       valid;
  logic                       ready;
  logic [kcl_pkg::LevelW-1:0] button_levels;

  modport source (output valid, output button_levels, input ready);
  modport sink   (input valid, input button_levels, output ready);
endinterface

interface kcl_result_if;
  logic                     valid;
  logic                     ready;
  logic                     press_seen;
  logic [kcl_pkg::KeyW-1:0] pressed_key;
  logic [kcl_pkg::LenW-1:0] digits_matched;
  logic                     unlocked;

  modport source (output valid, output press_seen, output pressed_key,
                  output digits_matched, output unlocked, input ready);
  modport sink   (input valid, input press_seen, input pressed_key,
                  input digits_matched, input unlocked, output ready);
endinterface

interface kcl_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [kcl_pkg::CfgIdxW-1:0] index;
  logic [kcl_pkg::CodeW-1:0]   data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/kcl_in_stage.sv =====
// ----------------------------------------------------------------------------
// kcl_in_stage
// input register for scan beats; refills in the cycle the core takes a beat
// ----------------------------------------------------------------------------
module kcl_in_stage (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       valid_i,
  input  logic [kcl_pkg::LevelW-1:0] levels_i,
  output logic                       ready_o,
  input  logic                       take_i,
  output kcl_pkg::stage_t            stage_o
);

  logic                       valid_q, valid_d;
  logic [kcl_pkg::LevelW-1:0] levels_q;
  logic                       accept;

  assign ready_o = !valid_q || take_i;
  assign accept  = valid_i && ready_o;

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      levels_q <= levels_i;
    end
  end

  assign stage_o.valid  = valid_q;
  assign stage_o.levels = levels_q;

endmodule

// ===== rtl/kcl_lock_core.sv =====
// ----------------------------------------------------------------------------
// kcl_lock_core
// edge detect, key select, digit compare, lock state and result register
// ----------------------------------------------------------------------------
module kcl_lock_core (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  kcl_pkg::stage_t           stage_i,
  output logic                      take_o,
  input  logic [kcl_pkg::CodeW-1:0] code_digits_i,
  input  logic [kcl_pkg::LenW-1:0]  code_length_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output kcl_pkg::result_t          result_o
);

  logic [kcl_pkg::LevelW-1:0] prev_q, prev_d;
  logic [kcl_pkg::LenW-1:0]   progress_q, progress_d;
  logic                       open_q, open_d;
  logic                       out_valid_q, out_valid_d;
  kcl_pkg::result_t           result_q, result_d;

  logic [kcl_pkg::LevelW-1:0] levels;
  logic [kcl_pkg::LevelW-1:0] rising;
  logic                       seen;
  logic [kcl_pkg::KeyW-1:0]   key;
  logic [kcl_pkg::LenW-1:0]   len_eff;
  logic [kcl_pkg::DigitW-1:0] digit;
  logic                       match;
  logic [kcl_pkg::LenW-1:0]   prog_next;

  assign take_o = stage_i.valid && (!out_valid_q || out_ready_i);

  assign levels  = stage_i.levels & kcl_pkg::KeyMask;
  assign rising  = levels & ~prev_q;
  assign seen    = |rising;
  assign key     = kcl_pkg::lowest_set(rising);
  assign len_eff = (code_length_i > kcl_pkg::MaxLen) ? kcl_pkg::MaxLen : code_length_i;
  assign digit   = code_digits_i[{progress_q[2:0], 2'b00} +: kcl_pkg::DigitW];
  assign match   = (progress_q < len_eff) && (digit == key);

  always_comb begin
    prog_next = progress_q;
    if (seen) begin
      prog_next = match ? progress_q + 1'b1 : '0;
    end
  end

  always_comb begin
    prev_d      = prev_q;
    progress_d  = progress_q;
    open_d      = open_q;
    result_d    = result_q;
    out_valid_d = out_valid_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (take_o) begin
      out_valid_d = 1'b1;
      if (open_q) begin
        result_d.press_seen     = 1'b0;
        result_d.pressed_key    = '0;
        result_d.digits_matched = progress_q;
        result_d.unlocked       = 1'b1;
      end else begin
        prev_d                  = levels;
        progress_d              = prog_next;
        open_d                  = (prog_next >= len_eff);
        result_d.press_seen     = seen;
        result_d.pressed_key    = key;
        result_d.digits_matched = prog_next;
        result_d.unlocked       = (prog_next >= len_eff);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q      <= '0;
      progress_q  <= '0;
      open_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      prev_q      <= prev_d;
      progress_q  <= progress_d;
      open_q      <= open_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    result_q <= result_d;
  end

  assign out_valid_o = out_valid_q;
  assign result_o    = result_q;

  // once open, the lock stays open until reset
  a_open_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    open_q |=> open_q) else $error("lock closed without reset");

  // no scan history is kept while open
  a_prev_frozen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    open_q |=> $stable(prev_q)) else $error("scan history moved while open");

  a_progress_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    progress_q <= kcl_pkg::MaxLen) else $error("progress out of range");

  a_key_without_press: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !result_q.press_seen) |-> (result_q.pressed_key == '0))
    else $error("key reported without a press");

  a_open_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take_o && open_q) |=> (result_q.unlocked && !result_q.press_seen))
    else $error("open lock reported a press");

endmodule

// ===== rtl/keypad_code_lock.sv =====
// ----------------------------------------------------------------------------
// keypad_code_lock
// combination lock fed by keypad scans: lowest-numbered rising button is the key press,
// compared in order against a configurable code of up to eight digits
//
//   channel  | dir | beat
//   ---------+-----+--------------------------------------------------------
//   scan_i   | in  | button_levels
//   result_o | out | press_seen, pressed_key, digits_matched, unlocked
//   cfg_i    | in  | index (0 code_digits, 1 code_length), data
//
// one scan per cycle sustained while results drain; each scan beat passes
// the input register, then edge/compare logic into the result register
// a stalled result register holds the input register, which still takes a
// new scan in the cycle the result drains; config writes are always ready
// reset restores the default code 1,3,3,7,1,9,8,5 of length eight, locked
// ----------------------------------------------------------------------------
module keypad_code_lock (
  input  logic        clk_i,
  input  logic        rst_ni,
  kcl_cfg_if.sink     cfg_i,
  kcl_scan_if.sink    scan_i,
  kcl_result_if.source result_o
);

  logic [kcl_pkg::CodeW-1:0] code_digits_q;
  logic [kcl_pkg::LenW-1:0]  code_length_q;
  logic                      cfg_write;
  logic                      take;
  kcl_pkg::stage_t           stage;
  kcl_pkg::result_t          result;

  assign cfg_i.ready = 1'b1;
  assign cfg_write   = cfg_i.valid && cfg_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      code_digits_q <= kcl_pkg::ResetCodeDigits;
      code_length_q <= kcl_pkg::ResetCodeLength;
    end else if (cfg_write) begin
      unique case (cfg_i.index)
        kcl_pkg::CfgCodeDigits: code_digits_q <= cfg_i.data;
        kcl_pkg::CfgCodeLength: code_length_q <= cfg_i.data[kcl_pkg::LenW-1:0];
        default: ;
      endcase
    end
  end

  kcl_in_stage u_in_stage (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (scan_i.valid),
    .levels_i (scan_i.button_levels),
    .ready_o  (scan_i.ready),
    .take_i   (take),
    .stage_o  (stage)
  );

  kcl_lock_core u_lock_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .stage_i       (stage),
    .take_o        (take),
    .code_digits_i (code_digits_q),
    .code_length_i (code_length_q),
    .out_valid_o   (result_o.valid),
    .out_ready_i   (result_o.ready),
    .result_o      (result)
  );

  assign result_o.press_seen     = result.press_seen;
  assign result_o.pressed_key    = result.pressed_key;
  assign result_o.digits_matched = result.digits_matched;
  assign result_o.unlocked       = result.unlocked;

endmodule
